@@ rtl/core/ppmt_pkg.sv @@
`default_nettype none

package ppmt_pkg;

    // Configuration register map
    localparam int ADDR_W     = 3;
    localparam int APB_DATA_W = 32;
    localparam int INTERVAL_W = 7;
    localparam int LIMIT_W    = 16;

    localparam logic REG_UPLOAD_INTERVAL   = 1'b0;
    localparam logic REG_OVERCURRENT_LIMIT = 1'b1;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 7'd10;
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 16'd6780;

    // Tick counter
    localparam int              TICK_W   = 8;
    localparam logic [TICK_W-1:0] TICK_MAX = 8'd255;

    // Result field widths
    localparam int POWER_W   = 30;
    localparam int ENERGY_W  = 20;
    localparam int CHANNEL_W = 23;
    localparam int BYTES_W   = 3;
    localparam int ALARM_W   = 3;

    // Alarm bit positions
    localparam int ALM_OVERCURRENT = 0;
    localparam int ALM_UNPLUGGED   = 1;
    localparam int ALM_POWER_LOSS  = 2;

    // Scale factors
    localparam int unsigned POWER_MUL   = 14601;
    localparam int unsigned ENERGY_DIV  = 1000;
    localparam int unsigned ENERGY_INT  = POWER_MUL / ENERGY_DIV;
    localparam int unsigned CURRENT_MUL = 118;
    localparam int unsigned VOLT_MUL    = 1317;
    localparam int unsigned VOLT_DIV    = 10000;

    // Reciprocals scaled by 2^RECIP_SHIFT, rounded down:
    //   ENERGY_RECIP = floor(0.601  * 2^32)  (fractional part of 14.601)
    //   VOLT_RECIP   = floor(0.1317 * 2^32)
    // The estimate is low by at most one for counts below 2^32.
    localparam int          RECIP_SHIFT  = 32;
    localparam logic [31:0] ENERGY_RECIP = 32'd2581275344;
    localparam logic [31:0] VOLT_RECIP   = 32'd565647192;

    localparam int VAL_W = 64;

    typedef struct packed {
        logic [INTERVAL_W-1:0] upload_interval;
        logic [LIMIT_W-1:0]    overcurrent_limit;
    } t_cfg;

    typedef struct packed {
        logic               is_volt;
        logic               select_level;
        logic               upload_now;
        logic [ALARM_W-1:0] alarm_flags;
        logic               relay_open;
    } t_tick_info;

    function automatic logic [BYTES_W-1:0] bytes_needed(input logic [VAL_W-1:0] v);
        logic [BYTES_W-1:0] n;
        if (v <= 64'hFF) begin
            n = 3'd1;
        end else if (v <= 64'hFFFF) begin
            n = 3'd2;
        end else if (v <= 64'hFF_FFFF) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ppmt_if.sv @@
`default_nettype none

interface ppmt_tick_if #(
    parameter int COUNT_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] power_pulses;
    logic [COUNT_BITS-1:0] channel_pulses;

    modport source (output valid, output power_pulses, output channel_pulses, input ready);
    modport sink   (input valid, input power_pulses, input channel_pulses, output ready);
endinterface

interface ppmt_result_if;
    import ppmt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [POWER_W-1:0]   power_scaled;
    logic [BYTES_W-1:0]   power_bytes;
    logic [ENERGY_W-1:0]  energy_scaled;
    logic [BYTES_W-1:0]   energy_bytes;
    logic                 channel_is_voltage;
    logic [CHANNEL_W-1:0] channel_scaled;
    logic [BYTES_W-1:0]   channel_bytes;
    logic                 select_level;
    logic                 upload_now;
    logic [ALARM_W-1:0]   alarm_flags;
    logic                 relay_open;

    modport source (
        output valid, input ready,
        output power_scaled, output power_bytes, output energy_scaled, output energy_bytes,
        output channel_is_voltage, output channel_scaled, output channel_bytes,
        output select_level, output upload_now, output alarm_flags, output relay_open
    );
    modport sink (
        input valid, output ready,
        input power_scaled, input power_bytes, input energy_scaled, input energy_bytes,
        input channel_is_voltage, input channel_scaled, input channel_bytes,
        input select_level, input upload_now, input alarm_flags, input relay_open
    );
endinterface

`default_nettype wire

@@ rtl/core/ppmt_cfg.sv @@
`default_nettype none

module ppmt_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ppmt_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [ppmt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [ppmt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output ppmt_pkg::t_cfg                        o_cfg
);
    import ppmt_pkg::*;

    logic [INTERVAL_W-1:0] r_interval;
    logic [LIMIT_W-1:0]    r_limit;
    logic                  wr_en;
    logic                  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[ADDR_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RESET;
            r_limit    <= LIMIT_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_UPLOAD_INTERVAL:   r_interval <= pwdata[INTERVAL_W-1:0];
                REG_OVERCURRENT_LIMIT: r_limit    <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_UPLOAD_INTERVAL:   prdata = APB_DATA_W'(r_interval);
            REG_OVERCURRENT_LIMIT: prdata = APB_DATA_W'(r_limit);
            default:               prdata = '0;
        endcase
    end

    assign o_cfg.upload_interval   = r_interval;
    assign o_cfg.overcurrent_limit = r_limit;

endmodule

`default_nettype wire

@@ rtl/core/ppmt_ctrl.sv @@
`default_nettype none

module ppmt_ctrl #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic [COUNT_BITS-1:0] i_power_pulses,
    input  wire logic [COUNT_BITS-1:0] i_channel_pulses,
    input  ppmt_pkg::t_cfg             i_cfg,
    output ppmt_pkg::t_tick_info       o_info
);
    import ppmt_pkg::*;

    logic                  r_phase;
    logic [TICK_W-1:0]     r_tick;
    logic [COUNT_BITS-1:0] r_volt;

    logic                  n_phase;
    logic [TICK_W-1:0]     n_tick;
    logic [COUNT_BITS-1:0] n_volt;

    logic [TICK_W-1:0]     tick_inc;
    logic                  upload;
    logic [ALARM_W-1:0]    flags;

    always_comb begin
        tick_inc = (r_tick < TICK_MAX) ? r_tick + 1'b1 : r_tick;
        upload   = tick_inc >= TICK_W'(i_cfg.upload_interval);
        // A voltage tick stores its count before the alarm check sees it
        n_volt   = r_phase ? i_channel_pulses : r_volt;
        n_phase  = ~r_phase;
        n_tick   = upload ? '0 : tick_inc;

        flags = '0;
        if (upload) begin
            flags[ALM_OVERCURRENT] = 32'(i_power_pulses) > 32'(i_cfg.overcurrent_limit);
            flags[ALM_UNPLUGGED]   = i_power_pulses <= COUNT_BITS'(1);
            flags[ALM_POWER_LOSS]  = n_volt == '0;
        end

        o_info.is_volt      = r_phase;
        o_info.select_level = n_phase;
        o_info.upload_now   = upload;
        o_info.alarm_flags  = flags;
        o_info.relay_open   = flags[ALM_OVERCURRENT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_tick  <= '0;
            r_volt  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_volt  <= n_volt;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ppmt_prod.sv @@
`default_nettype none

module ppmt_prod #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                    i_is_volt,
    input  wire logic [COUNT_BITS-1:0]   i_power_pulses,
    input  wire logic [COUNT_BITS-1:0]   i_channel_pulses,
    output logic      [COUNT_BITS+13:0]  o_power_prod,
    output logic      [COUNT_BITS+4:0]   o_energy_est,
    output logic      [COUNT_BITS+10:0]  o_channel_prod,
    output logic      [COUNT_BITS-1:0]   o_volt_est
);
    import ppmt_pkg::*;

    localparam int PW_W   = COUNT_BITS + 14;
    localparam int EN_W   = COUNT_BITS + 5;
    localparam int CH_W   = COUNT_BITS + 11;
    localparam int PROD_W = COUNT_BITS + RECIP_SHIFT;

    logic [PROD_W-1:0] energy_frac;
    logic [PROD_W-1:0] volt_frac;

    assign o_power_prod = PW_W'(i_power_pulses) * PW_W'(POWER_MUL);

    // Split 14.601 into its integer part and a low-biased reciprocal for 0.601
    assign energy_frac  = PROD_W'(i_power_pulses) * PROD_W'(ENERGY_RECIP);
    assign o_energy_est = EN_W'(i_power_pulses) * EN_W'(ENERGY_INT)
                        + EN_W'(energy_frac[PROD_W-1:RECIP_SHIFT]);

    assign o_channel_prod = i_is_volt ? CH_W'(i_channel_pulses) * CH_W'(VOLT_MUL)
                                      : CH_W'(i_channel_pulses) * CH_W'(CURRENT_MUL);

    assign volt_frac  = PROD_W'(i_channel_pulses) * PROD_W'(VOLT_RECIP);
    assign o_volt_est = volt_frac[PROD_W-1:RECIP_SHIFT];

endmodule

`default_nettype wire

@@ rtl/core/ppmt_scale.sv @@
`default_nettype none

module ppmt_scale #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                             i_is_volt,
    input  wire logic [COUNT_BITS+13:0]           i_power_prod,
    input  wire logic [COUNT_BITS+4:0]            i_energy_est,
    input  wire logic [COUNT_BITS+10:0]           i_channel_prod,
    input  wire logic [COUNT_BITS-1:0]            i_volt_est,
    output logic      [ppmt_pkg::POWER_W-1:0]     o_power_scaled,
    output logic      [ppmt_pkg::BYTES_W-1:0]     o_power_bytes,
    output logic      [ppmt_pkg::ENERGY_W-1:0]    o_energy_scaled,
    output logic      [ppmt_pkg::BYTES_W-1:0]     o_energy_bytes,
    output logic      [ppmt_pkg::CHANNEL_W-1:0]   o_channel_scaled,
    output logic      [ppmt_pkg::BYTES_W-1:0]     o_channel_bytes
);
    import ppmt_pkg::*;

    localparam int PW_W = COUNT_BITS + 14;
    localparam int EN_W = COUNT_BITS + 5;
    localparam int CH_W = COUNT_BITS + 11;

    logic [EN_W:0]         energy_inc;
    logic [PW_W:0]         energy_lim;
    logic [EN_W-1:0]       energy;
    logic [COUNT_BITS:0]   volt_inc;
    logic [CH_W:0]         volt_lim;
    logic [COUNT_BITS-1:0] volts;
    logic [CH_W-1:0]       channel;

    // Estimates are low by at most one: bump when the next multiple still fits
    assign energy_inc = {1'b0, i_energy_est} + 1'b1;
    assign energy_lim = (PW_W+1)'(energy_inc) * (PW_W+1)'(ENERGY_DIV);
    assign energy     = i_energy_est + EN_W'({1'b0, i_power_prod} >= energy_lim);

    assign volt_inc = {1'b0, i_volt_est} + 1'b1;
    assign volt_lim = (CH_W+1)'(volt_inc) * (CH_W+1)'(VOLT_DIV);
    assign volts    = i_volt_est + COUNT_BITS'({1'b0, i_channel_prod} >= volt_lim);
    assign channel  = i_is_volt ? CH_W'(volts) : i_channel_prod;

    assign o_power_scaled   = POWER_W'(i_power_prod);
    assign o_power_bytes    = bytes_needed(VAL_W'(i_power_prod));
    assign o_energy_scaled  = ENERGY_W'(energy);
    assign o_energy_bytes   = bytes_needed(VAL_W'(energy));
    assign o_channel_scaled = CHANNEL_W'(channel);
    assign o_channel_bytes  = bytes_needed(VAL_W'(channel));

endmodule

`default_nettype wire

@@ rtl/core/pulse_power_meter_tick_core.sv @@
// Pulse power meter tick core.
// One transaction on i_tick carries the power pulse count and the shared
// current/voltage pulse count gathered over one one-second tick. Each input
// transaction yields exactly one result transaction on o_result: scaled power,
// energy and channel value with their byte counts, the channel phase, the
// sensor select level for the next tick, the upload request, the alarm flags
// and the relay-open order.
// Path: input register, product register (constant multiplies), result register
// (reciprocal corrections and byte counts); throughput is one transaction per
// cycle while o_result.ready stays high, through that three-register pipeline.
// Stalls: when o_result.ready stays low, the result register holds, then the
// stages behind it fill; i_tick.ready drops only once all three are occupied.
// Reset (i_rst_n low, synchronous) empties the pipeline, returns to the current
// phase, clears the tick counter and stored voltage count, and loads the
// register defaults (upload interval 10, overcurrent limit 6780).
// Configuration: APB writes at address 0 (upload interval) and 4 (overcurrent
// limit); write only while no transaction is in flight.
`default_nettype none

module pulse_power_meter_tick_core #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    ppmt_tick_if.sink                             i_tick,
    ppmt_result_if.source                         o_result,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ppmt_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [ppmt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [ppmt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);
    import ppmt_pkg::*;

    localparam int PW_W = COUNT_BITS + 14;
    localparam int EN_W = COUNT_BITS + 5;
    localparam int CH_W = COUNT_BITS + 11;

    t_cfg       cfg;
    t_tick_info info;

    // Stage 0: input register
    logic                  r_v0;
    logic [COUNT_BITS-1:0] r_power0;
    logic [COUNT_BITS-1:0] r_channel0;

    // Stage 1: product register
    logic                  r_v1;
    t_tick_info            r_info1;
    logic [PW_W-1:0]       r_power_prod1;
    logic [EN_W-1:0]       r_energy_est1;
    logic [CH_W-1:0]       r_channel_prod1;
    logic [COUNT_BITS-1:0] r_volt_est1;

    // Stage 2: result register
    logic                 r_v2;
    t_tick_info           r_info2;
    logic [POWER_W-1:0]   r_power2;
    logic [BYTES_W-1:0]   r_power_bytes2;
    logic [ENERGY_W-1:0]  r_energy2;
    logic [BYTES_W-1:0]   r_energy_bytes2;
    logic [CHANNEL_W-1:0] r_channel2;
    logic [BYTES_W-1:0]   r_channel_bytes2;

    logic                  n_v0;
    logic                  n_v1;
    logic                  n_v2;

    logic [PW_W-1:0]       power_prod;
    logic [EN_W-1:0]       energy_est;
    logic [CH_W-1:0]       channel_prod;
    logic [COUNT_BITS-1:0] volt_est;

    logic [POWER_W-1:0]   power_scaled;
    logic [BYTES_W-1:0]   power_bytes;
    logic [ENERGY_W-1:0]  energy_scaled;
    logic [BYTES_W-1:0]   energy_bytes;
    logic [CHANNEL_W-1:0] channel_scaled;
    logic [BYTES_W-1:0]   channel_bytes;

    logic s2_free;
    logic s1_go;
    logic s1_free;
    logic s0_go;
    logic in_take;

    // Advance a stage whenever the one ahead is empty or emptying
    assign s2_free = ~r_v2 | o_result.ready;
    assign s1_go   = r_v1 & s2_free;
    assign s1_free = ~r_v1 | s2_free;
    assign s0_go   = r_v0 & s1_free;
    assign i_tick.ready = ~r_v0 | s1_free;
    assign in_take = i_tick.valid & i_tick.ready;

    assign n_v0 = in_take | (r_v0 & ~s0_go);
    assign n_v1 = s0_go | (r_v1 & ~s1_go);
    assign n_v2 = s1_go | (r_v2 & ~o_result.ready);

    ppmt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Tick state advances as a transaction leaves stage 0, in arrival order
    ppmt_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (s0_go),
        .i_power_pulses   (r_power0),
        .i_channel_pulses (r_channel0),
        .i_cfg            (cfg),
        .o_info           (info)
    );

    ppmt_prod #(
        .COUNT_BITS (COUNT_BITS)
    ) u_prod (
        .i_is_volt        (info.is_volt),
        .i_power_pulses   (r_power0),
        .i_channel_pulses (r_channel0),
        .o_power_prod     (power_prod),
        .o_energy_est     (energy_est),
        .o_channel_prod   (channel_prod),
        .o_volt_est       (volt_est)
    );

    ppmt_scale #(
        .COUNT_BITS (COUNT_BITS)
    ) u_scale (
        .i_is_volt        (r_info1.is_volt),
        .i_power_prod     (r_power_prod1),
        .i_energy_est     (r_energy_est1),
        .i_channel_prod   (r_channel_prod1),
        .i_volt_est       (r_volt_est1),
        .o_power_scaled   (power_scaled),
        .o_power_bytes    (power_bytes),
        .o_energy_scaled  (energy_scaled),
        .o_energy_bytes   (energy_bytes),
        .o_channel_scaled (channel_scaled),
        .o_channel_bytes  (channel_bytes)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    // Payload: load on advance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_power0   <= i_tick.power_pulses;
            r_channel0 <= i_tick.channel_pulses;
        end
        if (s0_go) begin
            r_info1         <= info;
            r_power_prod1   <= power_prod;
            r_energy_est1   <= energy_est;
            r_channel_prod1 <= channel_prod;
            r_volt_est1     <= volt_est;
        end
        if (s1_go) begin
            r_info2          <= r_info1;
            r_power2         <= power_scaled;
            r_power_bytes2   <= power_bytes;
            r_energy2        <= energy_scaled;
            r_energy_bytes2  <= energy_bytes;
            r_channel2       <= channel_scaled;
            r_channel_bytes2 <= channel_bytes;
        end
    end

    assign o_result.valid              = r_v2;
    assign o_result.power_scaled       = r_power2;
    assign o_result.power_bytes        = r_power_bytes2;
    assign o_result.energy_scaled      = r_energy2;
    assign o_result.energy_bytes       = r_energy_bytes2;
    assign o_result.channel_is_voltage = r_info2.is_volt;
    assign o_result.channel_scaled     = r_channel2;
    assign o_result.channel_bytes      = r_channel_bytes2;
    assign o_result.select_level       = r_info2.select_level;
    assign o_result.upload_now         = r_info2.upload_now;
    assign o_result.alarm_flags        = r_info2.alarm_flags;
    assign o_result.relay_open         = r_info2.relay_open;

endmodule

`default_nettype wire
